[hdl/lsfe_pkg.sv]
// Package for the LED strip frame encoder: sizes, command and result codes,
// sequencer phase codes, control/status structs and the wire code table.
// No dependencies.
package lsfe_pkg;

  localparam int STORE_BYTES = 256;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int FIFO_DEPTH  = 128;

  // command codes
  localparam logic [2:0] FN_SET    = 3'd0;
  localparam logic [2:0] FN_FILL   = 3'd1;
  localparam logic [2:0] FN_CLEAR  = 3'd2;
  localparam logic [2:0] FN_ROTATE = 3'd3;
  localparam logic [2:0] FN_AVG    = 3'd4;
  localparam logic [2:0] FN_START  = 3'd5;
  localparam logic [2:0] FN_REFILL = 3'd6;

  // result kinds
  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_AVG  = 2'd1;
  localparam logic [1:0] KIND_BYTE = 2'd2;

  // sequencer phases
  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_INIT   = 4'd0;
  localparam logic [ST_W-1:0] ST_IDLE   = 4'd1;
  localparam logic [ST_W-1:0] ST_DISP   = 4'd2;
  localparam logic [ST_W-1:0] ST_SET    = 4'd3;
  localparam logic [ST_W-1:0] ST_FILL   = 4'd4;
  localparam logic [ST_W-1:0] ST_RLOAD  = 4'd5;
  localparam logic [ST_W-1:0] ST_RMOVE  = 4'd6;
  localparam logic [ST_W-1:0] ST_RWAIT  = 4'd7;
  localparam logic [ST_W-1:0] ST_RPUT   = 4'd8;
  localparam logic [ST_W-1:0] ST_ASUM   = 4'd9;
  localparam logic [ST_W-1:0] ST_ADRAIN = 4'd10;
  localparam logic [ST_W-1:0] ST_ADIV   = 4'd11;
  localparam logic [ST_W-1:0] ST_AOUT   = 4'd12;
  localparam logic [ST_W-1:0] ST_ACK    = 4'd13;
  localparam logic [ST_W-1:0] ST_EMRD   = 4'd14;
  localparam logic [ST_W-1:0] ST_EMIT   = 4'd15;

  typedef struct packed {
    logic [ST_W-1:0] phase;
    logic            step_clr;  // phase changes: restart the step counter
    logic            in_ready;
  } lsfe_cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       init_end;
    logic       set_ok;
    logic       cnt_zero;
    logic       cnt_lt3;
    logic       cnt_eq3;
    logic       div_zero;
    logic       idx_eq2;
    logic       idx_end;
    logic       move_end;
    logic       div_end;
    logic       emit_go;
    logic       emit_last;
    logic [2:0] func;
  } lsfe_stat_t;

  // 2-bit group to 6-bit UART word
  function automatic logic [5:0] wire_code(input logic [1:0] bits);
    logic [5:0] w;
    case (bits)
      2'b00:   w = 6'h37;
      2'b01:   w = 6'h07;
      2'b10:   w = 6'h34;
      default: w = 6'h04;
    endcase
    return w;
  endfunction

endpackage

[hdl/lsfe_ifs.sv]
// Channel interfaces of the LED strip frame encoder: command input,
// result output and configuration write. No dependencies.
interface lsfe_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [15:0] pixel;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        direction;
  logic [7:0]  fifo_used;
  modport source (output valid, func, pixel, red, green, blue, direction, fifo_used,
                  input ready);
  modport sink   (input valid, func, pixel, red, green, blue, direction, fifo_used,
                  output ready);
endinterface

interface lsfe_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] avg_red;
  logic [7:0] avg_green;
  logic [7:0] avg_blue;
  logic       divide_error;
  logic [5:0] word_first;
  logic [5:0] word_second;
  logic [5:0] word_third;
  logic [5:0] word_fourth;
  logic       last;
  logic       transfer_done;
  modport source (output valid, kind, avg_red, avg_green, avg_blue, divide_error,
                  word_first, word_second, word_third, word_fourth, last,
                  transfer_done, input ready);
  modport sink   (input valid, kind, avg_red, avg_green, avg_blue, divide_error,
                  word_first, word_second, word_third, word_fourth, last,
                  transfer_done, output ready);
endinterface

interface lsfe_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[hdl/lsfe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hdl/lsfe_ctrl.sv]
// Sequencer of the LED strip frame encoder: walks the phases of each
// command. Depends on lsfe_pkg.
module lsfe_ctrl
  import lsfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  lsfe_stat_t stat,
  output lsfe_cmd_t  cmd
);
  logic [ST_W-1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:   if (stat.init_end) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_DISP;
      ST_DISP: begin
        case (stat.func) inside
          FN_SET:                state_nxt = stat.set_ok ? ST_SET : ST_ACK;
          FN_FILL, FN_CLEAR:     state_nxt = stat.cnt_zero ? ST_ACK : ST_FILL;
          FN_ROTATE:             state_nxt = stat.cnt_lt3 ? ST_ACK : ST_RLOAD;
          FN_AVG:                state_nxt = stat.div_zero ? ST_AOUT : ST_ASUM;
          FN_REFILL:             state_nxt = stat.emit_go ? ST_EMRD : ST_ACK;
          default:               state_nxt = ST_ACK;
        endcase
      end
      ST_SET:    if (stat.idx_eq2) state_nxt = ST_ACK;
      ST_FILL:   if (stat.idx_end) state_nxt = ST_ACK;
      ST_RLOAD:  if (stat.idx_eq2) state_nxt = stat.cnt_eq3 ? ST_RWAIT : ST_RMOVE;
      ST_RMOVE:  if (stat.move_end) state_nxt = ST_RWAIT;
      ST_RWAIT:  state_nxt = ST_RPUT;
      ST_RPUT:   if (stat.idx_eq2) state_nxt = ST_ACK;
      ST_ASUM:   if (stat.idx_end) state_nxt = ST_ADRAIN;
      ST_ADRAIN: state_nxt = ST_ADIV;
      ST_ADIV:   if (stat.div_end) state_nxt = ST_AOUT;
      ST_AOUT:   if (stat.out_free) state_nxt = ST_IDLE;
      ST_ACK:    if (stat.out_free) state_nxt = ST_IDLE;
      ST_EMRD:   state_nxt = ST_EMIT;
      ST_EMIT:   if (stat.out_free) state_nxt = stat.emit_last ? ST_IDLE : ST_EMRD;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.phase    = state_r;
  assign cmd.step_clr = (state_nxt != state_r);
  assign cmd.in_ready = (state_r == ST_IDLE);
endmodule

[hdl/lsfe_dp.sv]
// Datapath of the LED strip frame encoder: pixel store, step counter,
// rotate/average/transfer registers and the output register.
// Depends on lsfe_pkg, lsfe_ifs and lsfe_ram.
module lsfe_dp
  import lsfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  lsfe_in_if.sink    in_ch,
  lsfe_out_if.source out_ch,
  lsfe_cfg_if.sink   cfg_ch,
  input  lsfe_cmd_t  cmd,
  output lsfe_stat_t stat
);
  logic [7:0]  pixel_bytes_r;
  logic [2:0]  func_r;
  logic [15:0] pixel_r;
  logic [7:0]  red_r, green_r, blue_r, used_r;
  logic        dir_r;

  logic [7:0]  idx_r;
  logic [1:0]  mod3_r;
  logic [7:0]  held_r [3];
  logic        hv_r, av_r, wv_r;
  logic [1:0]  htag_r, atag_r;
  logic [7:0]  wa_r;
  logic [15:0] sum_r [3];   // green, red, blue
  logic [6:0]  rem_r [3];
  logic [6:0]  div_r;

  logic [7:0]  send_pos_r, send_end_r;
  logic        sending_r;
  logic [5:0]  avail_r, emit_r;
  logic        ack_done_r;

  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [7:0]  avg_r_r, avg_g_r, avg_b_r;
  logic        err_r, last_r, done_r;
  logic [5:0]  w1_r, w2_r, w3_r, w4_r;

  logic [7:0]  c;
  logic [17:0] pos3;
  logic [15:0] prod;
  logic [6:0]  div_c;
  logic [7:0]  space;
  logic [5:0]  avail_c;
  logic        emit_go;
  logic        out_load;
  logic [7:0]  hbase, pbase, src, dst;
  logic        we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]  wdata, rdata;

  function automatic logic [7:0] colour(input logic [1:0] m, input logic [7:0] g,
                                        input logic [7:0] r, input logic [7:0] b);
    logic [7:0] v;
    case (m)
      2'd0:    v = g;
      2'd1:    v = r;
      default: v = b;
    endcase
    return v;
  endfunction

  assign c       = pixel_bytes_r;
  assign pos3    = {2'b0, pixel_r} + {1'b0, pixel_r, 1'b0};
  assign prod    = c * 8'd171;             // c/3 for all 8-bit c
  assign div_c   = prod[15:9];
  assign space   = (used_r > 8'(FIFO_DEPTH)) ? 8'd0 : 8'(FIFO_DEPTH) - used_r;
  assign avail_c = space[7:2];
  assign emit_go = sending_r && (avail_c != 6'd0) && (send_pos_r < send_end_r);
  assign hbase   = dir_r ? 8'd0 : c - 8'd3;
  assign pbase   = dir_r ? c - 8'd3 : 8'd0;
  assign src     = dir_r ? idx_r + 8'd3 : c - 8'd4 - idx_r;
  assign dst     = dir_r ? idx_r : c - 8'd1 - idx_r;
  assign out_load = (!out_valid_r || out_ch.ready) &&
                    (cmd.phase == ST_ACK || cmd.phase == ST_AOUT || cmd.phase == ST_EMIT);

  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = 8'd0;
    raddr = idx_r;
    if (wv_r) begin
      we    = 1'b1;
      waddr = wa_r;
      wdata = rdata;
    end
    case (cmd.phase) inside
      ST_INIT: begin
        we = 1'b1;
      end
      ST_SET: begin
        we    = 1'b1;
        waddr = pos3[7:0] + idx_r;
        wdata = colour(idx_r[1:0], green_r, red_r, blue_r);
      end
      ST_FILL: begin
        we    = 1'b1;
        wdata = (func_r == FN_CLEAR) ? 8'd0 : colour(mod3_r, green_r, red_r, blue_r);
      end
      ST_RLOAD: raddr = hbase + idx_r;
      ST_RMOVE: raddr = src;
      ST_RPUT: begin
        we    = 1'b1;
        waddr = pbase + idx_r;
        wdata = held_r[idx_r[1:0]];
      end
      ST_EMRD, ST_EMIT: raddr = send_pos_r;
      default: ;
    endcase
  end

  lsfe_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_bytes_r <= 8'd0;
      idx_r         <= 8'd0;
      mod3_r        <= 2'd0;
      hv_r          <= 1'b0;
      av_r          <= 1'b0;
      wv_r          <= 1'b0;
      send_pos_r    <= 8'd0;
      send_end_r    <= 8'd0;
      sending_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        pixel_bytes_r <= cfg_ch.data;
      end
      if (cmd.step_clr) begin
        idx_r  <= 8'd0;
        mod3_r <= 2'd0;
      end else begin
        idx_r  <= idx_r + 8'd1;
        mod3_r <= (mod3_r == 2'd2) ? 2'd0 : mod3_r + 2'd1;
      end
      hv_r <= (cmd.phase == ST_RLOAD);
      av_r <= (cmd.phase == ST_ASUM);
      wv_r <= (cmd.phase == ST_RMOVE);
      if (cmd.phase == ST_DISP) begin
        if (func_r == FN_START) begin
          send_pos_r <= 8'd0;
          send_end_r <= c;
          sending_r  <= 1'b1;
        end else if (func_r == FN_REFILL && sending_r && !emit_go
                     && send_pos_r >= send_end_r) begin
          sending_r <= 1'b0;
        end
      end
      if (out_load && cmd.phase == ST_EMIT) begin
        send_pos_r <= send_pos_r + 8'd1;
        if (send_pos_r + 8'd1 == send_end_r) begin
          sending_r <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    logic [7:0] r2;
    if (in_ch.valid && cmd.in_ready) begin
      func_r  <= in_ch.func;
      pixel_r <= in_ch.pixel;
      red_r   <= in_ch.red;
      green_r <= in_ch.green;
      blue_r  <= in_ch.blue;
      dir_r   <= in_ch.direction;
      used_r  <= in_ch.fifo_used;
    end
    htag_r <= idx_r[1:0];
    atag_r <= mod3_r;
    wa_r   <= dst;
    if (hv_r) begin
      held_r[htag_r] <= rdata;
    end
    if (cmd.phase == ST_DISP) begin
      div_r      <= div_c;
      avail_r    <= avail_c;
      emit_r     <= 6'd0;
      ack_done_r <= (func_r == FN_REFILL) && sending_r && !emit_go
                    && (send_pos_r >= send_end_r);
      for (int k = 0; k < 3; k++) begin
        sum_r[k] <= 16'd0;
      end
    end
    if (av_r) begin
      sum_r[atag_r] <= sum_r[atag_r] + {8'd0, rdata};
    end
    if (cmd.phase == ST_ADRAIN) begin
      for (int k = 0; k < 3; k++) begin
        rem_r[k] <= 7'd0;
      end
    end
    // restoring division, one quotient bit per cycle on all three sums
    if (cmd.phase == ST_ADIV) begin
      for (int k = 0; k < 3; k++) begin
        r2 = {rem_r[k], sum_r[k][15]};
        if (r2 >= {1'b0, div_r}) begin
          r2 = r2 - {1'b0, div_r};
          sum_r[k] <= {sum_r[k][14:0], 1'b1};
        end else begin
          sum_r[k] <= {sum_r[k][14:0], 1'b0};
        end
        rem_r[k] <= r2[6:0];
      end
    end
    if (out_load) begin
      kind_r  <= KIND_ACK;
      avg_r_r <= 8'd0;
      avg_g_r <= 8'd0;
      avg_b_r <= 8'd0;
      err_r   <= 1'b0;
      w1_r    <= 6'd0;
      w2_r    <= 6'd0;
      w3_r    <= 6'd0;
      w4_r    <= 6'd0;
      last_r  <= 1'b1;
      done_r  <= 1'b0;
      case (cmd.phase)
        ST_ACK: done_r <= ack_done_r;
        ST_AOUT: begin
          kind_r  <= KIND_AVG;
          avg_r_r <= sum_r[1][7:0];
          avg_g_r <= sum_r[0][7:0];
          avg_b_r <= sum_r[2][7:0];
          err_r   <= (div_r == 7'd0);
        end
        default: begin
          kind_r <= KIND_BYTE;
          w1_r   <= wire_code(rdata[7:6]);
          w2_r   <= wire_code(rdata[5:4]);
          w3_r   <= wire_code(rdata[3:2]);
          w4_r   <= wire_code(rdata[1:0]);
          last_r <= stat.emit_last;
          done_r <= (send_pos_r + 8'd1 == send_end_r);
          emit_r <= emit_r + 6'd1;
        end
      endcase
    end
  end

  assign stat.out_free  = !out_valid_r || out_ch.ready;
  assign stat.init_end  = (idx_r == 8'(STORE_BYTES - 1));
  assign stat.set_ok    = (pos3 + 18'd2) < {10'd0, c};
  assign stat.cnt_zero  = (c == 8'd0);
  assign stat.cnt_lt3   = (c < 8'd3);
  assign stat.cnt_eq3   = (c == 8'd3);
  assign stat.div_zero  = (div_c == 7'd0);
  assign stat.idx_eq2   = (idx_r == 8'd2);
  assign stat.idx_end   = (idx_r == c - 8'd1);
  assign stat.move_end  = (idx_r == c - 8'd4);
  assign stat.div_end   = (idx_r == 8'd15);
  assign stat.emit_go   = emit_go;
  assign stat.emit_last = (emit_r + 6'd1 == avail_r) || (send_pos_r + 8'd1 == send_end_r);
  assign stat.func      = func_r;

  assign in_ch.ready         = cmd.in_ready;
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.avg_red      = avg_r_r;
  assign out_ch.avg_green    = avg_g_r;
  assign out_ch.avg_blue     = avg_b_r;
  assign out_ch.divide_error = err_r;
  assign out_ch.word_first   = w1_r;
  assign out_ch.word_second  = w2_r;
  assign out_ch.word_third   = w3_r;
  assign out_ch.word_fourth  = w4_r;
  assign out_ch.last         = last_r;
  assign out_ch.transfer_done = done_r;
endmodule

[hdl/led_strip_frame_encoder.sv]
// Top level of the LED strip frame encoder: sequencer plus datapath.
// Depends on lsfe_pkg, lsfe_ifs, lsfe_ctrl and lsfe_dp.
//
// Channels: in_ch takes one command per transaction (set pixel, fill, clear,
// rotate, average, start, refill); out_ch returns result transactions, the
// final one of each command flagged by last; cfg_ch writes pixel_bytes and
// is always ready (write it only while the block is idle).
// Reset: a clearing pass zeroes all 256 bytes of the pixel store, one byte per
// cycle; in_ch.ready stays low until it is done.
// Commands: one at a time, through the single store port (one write, one
// registered read per cycle). Set pixel writes three bytes, fill/clear
// walk the count, rotate moves the store by one group, average sums then
// divides, refill reads and emits each byte in turn, others acknowledge.
// Set pixel out of range, rotate or average under three bytes skip the work.
// Output: a result register sits between the sequencer and out_ch, so the
// next command is taken while the last result still waits. When the
// receiver stalls, the sequencer holds at its next result until the
// register frees up; nothing is dropped.
module led_strip_frame_encoder
  import lsfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  lsfe_in_if.sink    in_ch,
  lsfe_out_if.source out_ch,
  lsfe_cfg_if.sink   cfg_ch
);
  lsfe_cmd_t  cmd;
  lsfe_stat_t stat;

  lsfe_ctrl u_ctrl (
    .clk,
    .rst_n,
    .in_valid (in_ch.valid),
    .stat,
    .cmd
  );

  lsfe_dp u_dp (
    .clk,
    .rst_n,
    .in_ch,
    .out_ch,
    .cfg_ch,
    .cmd,
    .stat
  );
endmodule

[hdl/lsfe_checker.sv]
// Port-level checks of the LED strip frame encoder, bound to the top level.
// Depends on lsfe_pkg.
module lsfe_checker
  import lsfe_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [5:0] out_w1,
  input logic [5:0] out_w4,
  input logic       out_last,
  input logic       out_done
);
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind))
    else $error("stalled result dropped or changed");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_BYTE |->
      (out_w1 == 6'h37 || out_w1 == 6'h07 || out_w1 == 6'h34 || out_w1 == 6'h04) &&
      (out_w4 == 6'h37 || out_w4 == 6'h07 || out_w4 == 6'h34 || out_w4 == 6'h04))
    else $error("encoded word outside the code table");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done |-> out_last && out_kind != KIND_AVG)
    else $error("transfer done on a non-final result");
endmodule

bind led_strip_frame_encoder lsfe_checker u_lsfe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_w1    (out_ch.word_first),
  .out_w4    (out_ch.word_fourth),
  .out_last  (out_ch.last),
  .out_done  (out_ch.transfer_done)
);

[dv/lsfe_result_checker.sv]
// Result checker for the LED strip frame encoder: tracks the pixel store and
// transfer state, predicts results per command and compares them in order.
// Depends on lsfe_pkg and the channel interfaces in lsfe_ifs.
module lsfe_result_checker
  import lsfe_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  lsfe_in_if    in_mon,
  lsfe_out_if   out_mon,
  lsfe_cfg_if   cfg_mon,
  output int    fail_count,
  output int    pending
);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] avg_r;
    logic [7:0] avg_g;
    logic [7:0] avg_b;
    logic       div_err;
    logic [5:0] w1;
    logic [5:0] w2;
    logic [5:0] w3;
    logic [5:0] w4;
    logic       last;
    logic       done;
  } strip_result_t;

  localparam logic [5:0] UART_WORD [4] = '{6'h37, 6'h07, 6'h34, 6'h04};
  localparam int MAX_BYTES_PER_REFILL = 32;

  logic [7:0]    strip_bytes [STORE_BYTES];
  logic [7:0]    strip_len;
  int unsigned   tx_pos;
  int unsigned   tx_end;
  bit            tx_active;
  strip_result_t expected_results [$];

  initial fail_count = 0;
  initial pending = 0;

  function automatic void push_ack(bit done);
    strip_result_t r;
    r = '0;
    r.kind = KIND_ACK;
    r.last = 1'b1;
    r.done = done;
    expected_results.push_back(r);
  endfunction

  task automatic predict_command(input logic [2:0] fn, input logic [15:0] pix,
                                 input logic [7:0] red, input logic [7:0] green,
                                 input logic [7:0] blue, input logic dir,
                                 input logic [7:0] used);
    int unsigned   cnt;
    int unsigned   pos;
    int unsigned   div;
    int unsigned   space;
    int unsigned   avail;
    int unsigned   n;
    logic [15:0]   sr;
    logic [15:0]   sg;
    logic [15:0]   sb;
    logic [7:0]    snap [STORE_BYTES];
    logic [7:0]    b;
    strip_result_t r;
    cnt = strip_len;
    case (fn)
      FN_SET: begin
        pos = pix * 3;
        if (pos + 2 < cnt) begin
          strip_bytes[pos]     = green;
          strip_bytes[pos + 1] = red;
          strip_bytes[pos + 2] = blue;
        end
        push_ack(0);
      end
      FN_FILL: begin
        for (int i = 0; i < cnt; i++)
          strip_bytes[i] = (i % 3 == 0) ? green : (i % 3 == 1) ? red : blue;
        push_ack(0);
      end
      FN_CLEAR: begin
        for (int i = 0; i < cnt; i++) strip_bytes[i] = 8'd0;
        push_ack(0);
      end
      FN_ROTATE: begin
        if (cnt >= 3) begin
          snap = strip_bytes;
          if (dir) begin
            for (int i = 0; i < cnt - 3; i++) strip_bytes[i] = snap[i + 3];
            for (int k = 0; k < 3; k++) strip_bytes[cnt - 3 + k] = snap[k];
          end else begin
            for (int i = 3; i < cnt; i++) strip_bytes[i] = snap[i - 3];
            for (int k = 0; k < 3; k++) strip_bytes[k] = snap[cnt - 3 + k];
          end
        end
        push_ack(0);
      end
      FN_AVG: begin
        sr = '0; sg = '0; sb = '0;
        for (int i = 0; i < cnt; i++) begin
          if (i % 3 == 0) sg = sg + strip_bytes[i];
          else if (i % 3 == 1) sr = sr + strip_bytes[i];
          else sb = sb + strip_bytes[i];
        end
        r = '0;
        r.kind = KIND_AVG;
        r.last = 1'b1;
        div = cnt / 3;
        if (div == 0) begin
          r.div_err = 1'b1;
        end else begin
          r.avg_r = 8'(sr / div);
          r.avg_g = 8'(sg / div);
          r.avg_b = 8'(sb / div);
        end
        expected_results.push_back(r);
      end
      FN_START: begin
        tx_pos = 0;
        tx_end = cnt;
        tx_active = 1;
        push_ack(0);
      end
      FN_REFILL: begin
        space = (used > FIFO_DEPTH) ? 0 : FIFO_DEPTH - used;
        avail = space / 4;
        if (avail > MAX_BYTES_PER_REFILL) avail = MAX_BYTES_PER_REFILL;
        n = 0;
        if (!tx_active) begin
          push_ack(0);
        end else begin
          while (n < avail && tx_pos < tx_end && tx_pos < STORE_BYTES) begin
            b = strip_bytes[tx_pos];
            r = '0;
            r.kind = KIND_BYTE;
            r.w1 = UART_WORD[b[7:6]];
            r.w2 = UART_WORD[b[5:4]];
            r.w3 = UART_WORD[b[3:2]];
            r.w4 = UART_WORD[b[1:0]];
            expected_results.push_back(r);
            tx_pos++;
            n++;
          end
          if (n == 0) begin
            if (tx_pos >= tx_end) tx_active = 0;
            push_ack(tx_pos >= tx_end);
          end else begin
            expected_results[$].last = 1'b1;
            if (tx_pos >= tx_end) begin
              expected_results[$].done = 1'b1;
              tx_active = 0;
            end
          end
        end
      end
      default: push_ack(0);
    endcase
  endtask

  always @(posedge clk) begin
    strip_result_t got;
    strip_result_t want;
    if (!rst_n) begin
      foreach (strip_bytes[i]) strip_bytes[i] = 8'd0;
      strip_len = 8'd0;
      tx_pos = 0;
      tx_end = 0;
      tx_active = 0;
      expected_results.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) strip_len = cfg_mon.data;
      if (in_mon.valid && in_mon.ready)
        predict_command(in_mon.func, in_mon.pixel, in_mon.red, in_mon.green,
                        in_mon.blue, in_mon.direction, in_mon.fifo_used);
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.kind, out_mon.avg_red, out_mon.avg_green, out_mon.avg_blue,
                out_mon.divide_error, out_mon.word_first, out_mon.word_second,
                out_mon.word_third, out_mon.word_fourth, out_mon.last,
                out_mon.transfer_done};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected %h got %h", want, got);
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

[dv/led_strip_frame_encoder_tb.sv]
// Testbench top for the LED strip frame encoder: clock, reset, command and
// configuration stimulus, output backpressure and the verdict.
// Depends on lsfe_pkg, lsfe_ifs, led_strip_frame_encoder, lsfe_result_checker.
module led_strip_frame_encoder_tb;
  import lsfe_pkg::*;

  localparam logic [2:0] FN_UNUSED  = 3'd7;  // undefined command, plain ack
  localparam int         STALL_LIMIT = 20000;
  localparam int         RANDOM_ITEMS = 230;

  logic clk;
  logic rst_n;
  bit   calm;       // when set, neither side idles
  int   fail_count;
  int   pending;
  int   items;

  lsfe_in_if  in_ch ();
  lsfe_out_if out_ch ();
  lsfe_cfg_if cfg_ch ();

  led_strip_frame_encoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lsfe_result_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: random backpressure, none while calm.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 36);
    end
  end

  // Watchdog: ends the run if no transaction moves on any channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("led_strip_frame_encoder_tb: FAIL");
        $finish;
      end
    end
  end

  // One command transaction. Called at a rising edge; returns at the edge of
  // acceptance. Valid is lowered only in idle cycles, so back-to-back commands
  // keep it high with a single assignment per step.
  task automatic send_cmd(input logic [2:0] fn, input logic [15:0] pix,
                          input logic [7:0] red, input logic [7:0] green,
                          input logic [7:0] blue, input logic dir,
                          input logic [7:0] used);
    while (!calm && $urandom_range(0, 99) < 36) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= fn;
    in_ch.pixel     <= pix;
    in_ch.red       <= red;
    in_ch.green     <= green;
    in_ch.blue      <= blue;
    in_ch.direction <= dir;
    in_ch.fifo_used <= used;
    // ready is stable from the falling edge to the next rising edge
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    items++;
  endtask

  task automatic send_simple(input logic [2:0] fn, input logic dir);
    send_cmd(fn, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), dir,
             8'($urandom));
  endtask

  task automatic send_refill(input logic [7:0] used);
    send_cmd(FN_REFILL, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
             1'($urandom), used);
  endtask

  // Register write only with the block idle: every result back, then a margin.
  // One edge first so the count includes the command just accepted.
  task automatic write_strip_len(input logic [7:0] len);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= len;
    do @(negedge clk); while (!cfg_ch.ready);
    @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Start plus enough refills to drain the strip; FIFO fill level mostly low
  // so several bytes go out per refill, sometimes over depth.
  task automatic run_transfer(input int len);
    logic [7:0] used;
    send_simple(FN_START, 1'b0);
    repeat (len / 8 + 2) begin
      case ($urandom_range(0, 9))
        0:       used = 8'($urandom_range(129, 255));
        1, 2:    used = 8'($urandom_range(100, 128));
        default: used = 8'($urandom_range(0, 40));
      endcase
      send_refill(used);
    end
  endtask

  task automatic random_cmd(input int len);
    int pick;
    logic [15:0] pix;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      pix = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 90));
      send_cmd(FN_SET, pix, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
               8'($urandom));
    end else if (pick < 28) send_simple(FN_FILL, 1'($urandom));
    else if (pick < 33) send_simple(FN_CLEAR, 1'($urandom));
    else if (pick < 50) send_simple(FN_ROTATE, 1'($urandom));
    else if (pick < 62) send_simple(FN_AVG, 1'($urandom));
    else if (pick < 66) send_simple(FN_UNUSED, 1'($urandom));
    else if (pick < 72) send_refill(8'($urandom));
    else run_transfer(len);
  endtask

  initial begin
    int len;
    int phase;
    calm  = 1'b0;
    items = 0;
    rst_n = 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= FN_SET;
    in_ch.pixel     <= '0;
    in_ch.red       <= '0;
    in_ch.green     <= '0;
    in_ch.blue      <= '0;
    in_ch.direction <= 1'b0;
    in_ch.fifo_used <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty strip after reset - divide error, zero-length transfer
    // done on the first refill, refill while idle, undefined command.
    send_simple(FN_AVG, 1'b0);
    send_refill(8'd0);
    send_simple(FN_START, 1'b0);
    send_refill(8'd0);
    send_simple(FN_UNUSED, 1'b0);

    // Full strip: extremes of colour and pixel index, both rotations,
    // refill with over-depth, exactly full and empty FIFO.
    write_strip_len(8'd255);
    send_cmd(FN_FILL, 16'd0, 8'hff, 8'hff, 8'hff, 1'b0, 8'd0);
    send_cmd(FN_SET, 16'd0, 8'h00, 8'h5a, 8'ha5, 1'b0, 8'd0);
    send_cmd(FN_SET, 16'd84, 8'h12, 8'h34, 8'h56, 1'b1, 8'd0);
    send_cmd(FN_SET, 16'd85, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0);   // past the end
    send_cmd(FN_SET, 16'hffff, 8'h00, 8'h00, 8'h00, 1'b1, 8'hff);
    send_simple(FN_ROTATE, 1'b1);
    send_simple(FN_ROTATE, 1'b0);
    send_simple(FN_AVG, 1'b0);
    send_simple(FN_START, 1'b0);
    send_refill(8'd200);
    send_refill(8'd128);
    send_refill(8'd0);
    send_refill(8'd127);
    send_simple(FN_CLEAR, 1'b0);

    // Count not a multiple of three: rotation moves the trailing group.
    write_strip_len(8'd7);
    send_cmd(FN_FILL, 16'd0, 8'h81, 8'h42, 8'h24, 1'b0, 8'd0);
    send_cmd(FN_SET, 16'd1, 8'h01, 8'h02, 8'h03, 1'b0, 8'd0);
    send_simple(FN_ROTATE, 1'b1);
    send_simple(FN_ROTATE, 1'b0);
    send_simple(FN_AVG, 1'b0);

    // Random phases, mostly short strips; the first phase without any idling.
    phase = 0;
    while (items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(0, 2);
        1:       len = 3;
        2:       len = 255;
        3:       len = $urandom_range(100, 255);
        default: len = $urandom_range(4, 40);
      endcase
      write_strip_len(8'(len));
      calm = (phase == 0);
      repeat (20) begin
        if (items < RANDOM_ITEMS) random_cmd(len);
      end
      phase++;
    end
    calm = 1'b0;

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("led_strip_frame_encoder_tb: PASS");
    end else begin
      $display("led_strip_frame_encoder_tb: FAIL");
    end
    $finish;
  end

endmodule
